@@ rtl/dtsu_pkg.sv @@
`default_nettype none
package dtsu_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Result queue between the scanner and the output port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] K_COMMA     = 4'd0;
    localparam logic [3:0] K_PERIOD    = 4'd1;
    localparam logic [3:0] K_QMARK     = 4'd2;
    localparam logic [3:0] K_LPAREN    = 4'd3;
    localparam logic [3:0] K_RPAREN    = 4'd4;
    localparam logic [3:0] K_COLON     = 4'd5;
    localparam logic [3:0] K_COLONDASH = 4'd6;
    localparam logic [3:0] K_STRING    = 4'd7;
    localparam logic [3:0] K_ID        = 4'd8;
    localparam logic [3:0] K_KEYWORD0  = 4'd9;
    localparam logic [3:0] K_UNKNOWN   = 4'd13;
    localparam logic [3:0] K_END       = 4'd14;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam int KW_COUNT   = 4;
    localparam int KW_MAX_LEN = 7;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h46, 8'h61, 8'h63, 8'h74, 8'h73, 8'h00, 8'h00},  // Facts
        '{8'h52, 8'h75, 8'h6C, 8'h65, 8'h73, 8'h00, 8'h00},  // Rules
        '{8'h51, 8'h75, 8'h65, 8'h72, 8'h69, 8'h65, 8'h73},  // Queries
        '{8'h53, 8'h63, 8'h68, 8'h65, 8'h6D, 8'h65, 8'h73}   // Schemes
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd5, 3'd7, 3'd7};

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_STRING  = 3'd1,
        M_IDENT   = 3'd2,
        M_COLON   = 3'd3,
        M_COMMENT = 3'd4,
        M_DONE    = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_length;
        logic [15:0] token_total;
        logic        is_last;
    } t_out;

    // Bit k is set when character c matches keyword k at position pos.
    function automatic logic [KW_COUNT-1:0] kw_match(logic [2:0] pos, logic [7:0] c);
        logic [KW_COUNT-1:0] m;
        m = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos < KW_LEN[k] && KW_TEXT[k][pos] == c) begin
                m[k] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_good(logic [3:0] kind);
        return kind != K_UNKNOWN && kind != K_END;
    endfunction

endpackage
`default_nettype wire

@@ rtl/datalog_token_scanner_unit.sv @@
`default_nettype none
// Channel  Direction  Handshake                 Payload
// input    in         i_valid / o_stall         i_data  (char_in, end_of_input)
// output   out        o_valid / i_stall         o_data  (kind, line, length, total, last)
//
// One character word is accepted per cycle while o_stall is low; the scan state updates in that cycle
// and its zero to two tokens enter a four-entry result queue.
// A word that gives two tokens fills two queue entries, so the sustained rate is
// one word per cycle only while each word gives at most one token.
// o_stall rises when fewer than two queue entries are free.
// Reset is synchronous and active low; after the end word the block yields nothing
// until reset.
module datalog_token_scanner_unit #(
    parameter int LINE_BITS   = dtsu_pkg::LINE_BITS_DEF,
    parameter int LENGTH_BITS = dtsu_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = dtsu_pkg::COUNT_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  dtsu_pkg::t_in  i_data,
    output logic           o_valid,
    input  wire            i_stall,
    output dtsu_pkg::t_out o_data
);
    import dtsu_pkg::*;

    t_mode                   r_mode, n_mode;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [LINE_BITS-1:0]    r_start, n_start;
    logic [LENGTH_BITS-1:0]  r_len, n_len;
    logic [KW_COUNT-1:0]     r_alive, n_alive;
    logic [COUNT_BITS-1:0]   r_count, n_count;

    t_out                    r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]    r_wr, r_rd;
    logic [QPTR_BITS:0]      r_fill, n_fill;

    logic                    in_acc, out_acc;
    logic [7:0]              c;
    logic                    do_idle;
    logic                    a_v, b_v;
    logic [3:0]              a_kind, b_kind, kw_kind;
    logic [LINE_BITS-1:0]    a_line, b_line, line_inc;
    logic [LENGTH_BITS-1:0]  a_len, b_len, len_inc;
    logic [COUNT_BITS-1:0]   cnt_a, cnt_b;
    logic [KW_COUNT-1:0]     keep;
    t_out                    res_a, res_b, w0, w1;
    logic [1:0]              nwr;

    function automatic logic [15:0] fit_line(logic [LINE_BITS-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[15:0];
    endfunction

    function automatic logic [15:0] fit_len(logic [LENGTH_BITS-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[15:0];
    endfunction

    function automatic logic [15:0] fit_count(logic [COUNT_BITS-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[15:0];
    endfunction

    assign o_stall = r_fill > (QPTR_BITS+1)'(QUEUE_DEPTH - 2);
    assign o_valid = r_fill != '0;
    assign o_data  = r_queue[r_rd];
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign c       = i_data.char_in;

    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;
    assign len_inc  = (r_len == '1) ? r_len : r_len + 1'b1;
    assign keep     = (r_len < LENGTH_BITS'(KW_MAX_LEN)) ? kw_match(r_len[2:0], c) : '0;

    always_comb begin
        kw_kind = K_ID;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (r_alive[k] && r_len == LENGTH_BITS'(KW_LEN[k])) begin
                kw_kind = K_KEYWORD0 + 4'(k);
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_start = r_start;
        n_len   = r_len;
        n_alive = r_alive;
        do_idle = 1'b0;
        a_v     = 1'b0;
        a_kind  = K_ID;
        a_line  = r_start;
        a_len   = r_len;
        b_v     = 1'b0;
        b_kind  = K_UNKNOWN;
        b_line  = r_line;
        b_len   = LENGTH_BITS'(1);

        if (in_acc && r_mode != M_DONE) begin
            if (i_data.end_of_input) begin
                unique case (r_mode)
                    M_STRING: begin
                        a_v    = 1'b1;
                        a_kind = K_UNKNOWN;
                    end
                    M_IDENT: begin
                        a_v    = 1'b1;
                        a_kind = kw_kind;
                    end
                    M_COLON: begin
                        a_v    = 1'b1;
                        a_kind = K_COLON;
                        a_len  = LENGTH_BITS'(1);
                    end
                    default: begin
                        a_v = 1'b0;
                    end
                endcase
                b_v     = 1'b1;
                b_kind  = K_END;
                b_len   = '0;
                n_mode  = M_DONE;
                n_len   = '0;
                n_alive = '1;
            end else begin
                unique case (r_mode)
                    M_STRING: begin
                        if (c == CH_QUOTE) begin
                            a_v    = 1'b1;
                            a_kind = K_STRING;
                            n_mode = M_IDLE;
                        end else if (c == CH_LF || c == CH_CR) begin
                            // The line break is swallowed without advancing the line.
                            a_v    = 1'b1;
                            a_kind = K_UNKNOWN;
                            n_mode = M_IDLE;
                        end else begin
                            n_len = len_inc;
                        end
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            n_alive = r_alive & keep;
                            n_len   = len_inc;
                        end else begin
                            a_v     = 1'b1;
                            a_kind  = kw_kind;
                            do_idle = 1'b1;
                        end
                    end
                    M_COLON: begin
                        if (c == CH_DASH) begin
                            a_v    = 1'b1;
                            a_kind = K_COLONDASH;
                            a_len  = LENGTH_BITS'(2);
                            n_mode = M_IDLE;
                        end else begin
                            a_v     = 1'b1;
                            a_kind  = K_COLON;
                            a_len   = LENGTH_BITS'(1);
                            do_idle = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (c == CH_LF || c == CH_CR) begin
                            n_line = line_inc;
                            n_mode = M_IDLE;
                        end
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase

                // A character met in idle mode, or one that closed the previous token, is scanned here.
                if (do_idle) begin
                    n_mode = M_IDLE;
                    case (c) inside
                        CH_HASH: n_mode = M_COMMENT;
                        CH_LF, CH_CR: n_line = line_inc;
                        CH_COMMA: begin
                            b_v    = 1'b1;
                            b_kind = K_COMMA;
                        end
                        CH_PERIOD: begin
                            b_v    = 1'b1;
                            b_kind = K_PERIOD;
                        end
                        CH_QMARK: begin
                            b_v    = 1'b1;
                            b_kind = K_QMARK;
                        end
                        CH_LPAREN: begin
                            b_v    = 1'b1;
                            b_kind = K_LPAREN;
                        end
                        CH_RPAREN: begin
                            b_v    = 1'b1;
                            b_kind = K_RPAREN;
                        end
                        CH_SPACE, CH_TAB, CH_VT, CH_FF: begin
                            n_mode = M_IDLE;
                        end
                        CH_QUOTE: begin
                            n_mode  = M_STRING;
                            n_start = r_line;
                            n_len   = '0;
                        end
                        CH_COLON: begin
                            n_mode  = M_COLON;
                            n_start = r_line;
                        end
                        default: begin
                            if (is_alpha(c)) begin
                                n_mode  = M_IDENT;
                                n_start = r_line;
                                n_len   = LENGTH_BITS'(1);
                                n_alive = kw_match(3'd0, c);
                            end else begin
                                b_v    = 1'b1;
                                b_kind = K_UNKNOWN;
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign cnt_a   = (a_v && is_good(a_kind) && r_count != '1) ? r_count + 1'b1 : r_count;
    assign cnt_b   = (b_v && is_good(b_kind) && cnt_a != '1) ? cnt_a + 1'b1 : cnt_a;
    assign n_count = cnt_b;

    always_comb begin
        res_a.token_kind   = a_kind;
        res_a.token_line   = fit_line(a_line);
        res_a.token_length = fit_len(a_len);
        res_a.token_total  = fit_count(cnt_a);
        res_a.is_last      = !b_v;
        res_b.token_kind   = b_kind;
        res_b.token_line   = fit_line(b_line);
        res_b.token_length = fit_len(b_len);
        res_b.token_total  = fit_count(cnt_b);
        res_b.is_last      = 1'b1;
        w0  = a_v ? res_a : res_b;
        w1  = res_b;
        nwr = {1'b0, a_v} + {1'b0, b_v};
    end

    assign n_fill = r_fill + (QPTR_BITS+1)'(nwr) - (QPTR_BITS+1)'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= LINE_BITS'(1);
            r_start <= LINE_BITS'(1);
            r_len   <= '0;
            r_alive <= '1;
            r_count <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_fill  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_start <= n_start;
            r_len   <= n_len;
            r_alive <= n_alive;
            r_count <= n_count;
            r_wr    <= r_wr + QPTR_BITS'(nwr);
            r_fill  <= n_fill;
            if (out_acc) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (nwr != 2'd0) begin
            r_queue[r_wr] <= w0;
        end
        if (nwr == 2'd2) begin
            r_queue[r_wr + 1'b1] <= w1;
        end
    end

endmodule
`default_nettype wire
